/* design/onewire_rom_search_macros.svh */
// Assertion macros shared by the search-ROM engine modules.
`ifndef ONEWIRE_ROM_SEARCH_MACROS_SVH
`define ONEWIRE_ROM_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ows_pkg.sv */
// Types and constants of the search-ROM decision engine.
package ows_pkg;

  localparam int unsigned RomW      = 64;
  localparam int unsigned PosW      = 7;
  localparam int unsigned FamDiscW  = 4;
  localparam int unsigned CountW    = 16;
  localparam int unsigned FamilyBits = 8;

  localparam logic [PosW-1:0] FamilyLimit = 7'd9;
  localparam logic [PosW-1:0] EndPosition = 7'd65;
  localparam logic [PosW-1:0] FirstPosition = 7'd1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_START = 2'd1,
    OP_BITS  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ACK      = 3'd0,
    ST_CONTINUE = 3'd1,
    ST_FOUND    = 3'd2,
    ST_FAILED   = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] op;
    logic       presence;
    logic       id_bit;
    logic       comp_bit;
  } item_t;

  typedef struct packed {
    logic [15:0]         device_count;
    logic [FamDiscW-1:0] family_discrepancy;
    logic                last_device;
    logic [RomW-1:0]     rom_address;
    logic                write_bit;
    logic                write_valid;
    status_t             status;
  } result_t;

endpackage

/* design/ows_core.sv */
// Search state registers and the per-request decision logic.
`include "onewire_rom_search_macros.svh"

module ows_core
  import ows_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  output result_t res
);

  logic [RomW-1:0]     rom_r, rom_nxt;
  logic [PosW-1:0]     last_disc_r, last_disc_nxt;
  logic [FamDiscW-1:0] fam_disc_r, fam_disc_nxt;
  logic                no_more_r, no_more_nxt;
  logic [PosW-1:0]     bit_pos_r, bit_pos_nxt;
  logic [PosW-1:0]     last_zero_r, last_zero_nxt;
  logic                active_r, active_nxt;
  logic [CountW-1:0]   count_r, count_nxt;

  logic [5:0]      idx;
  logic            dir;
  logic [PosW-1:0] lz_new;
  logic [PosW-1:0] pos_inc;
  logic [RomW-1:0] rom_upd;
  status_t         status;
  logic            wvalid;
  logic            wbit;

  always_comb begin
    rom_nxt       = rom_r;
    last_disc_nxt = last_disc_r;
    fam_disc_nxt  = fam_disc_r;
    no_more_nxt   = no_more_r;
    bit_pos_nxt   = bit_pos_r;
    last_zero_nxt = last_zero_r;
    active_nxt    = active_r;
    count_nxt     = count_r;
    status        = ST_IGNORED;
    wvalid        = 1'b0;
    wbit          = 1'b0;

    idx     = bit_pos_r[5:0] - 6'd1;
    pos_inc = bit_pos_r + 7'd1;
    lz_new  = last_zero_r;

    // Direction: a clean bit follows the bus, a discrepancy follows the
    // previous path below the last discrepancy, turns to one at it and takes zero above it.
    if (item.id_bit != item.comp_bit) begin
      dir = item.id_bit;
    end else if (bit_pos_r < last_disc_r) begin
      dir = rom_r[idx];
    end else begin
      dir = (bit_pos_r == last_disc_r);
    end
    if (item.id_bit == item.comp_bit && !dir) begin
      lz_new = bit_pos_r;
    end
    rom_upd      = rom_r;
    rom_upd[idx] = dir;

    case (item.op)
      OP_CLEAR: begin
        rom_nxt       = '0;
        last_disc_nxt = '0;
        fam_disc_nxt  = '0;
        no_more_nxt   = 1'b0;
        bit_pos_nxt   = FirstPosition;
        last_zero_nxt = '0;
        active_nxt    = 1'b0;
        count_nxt     = '0;
        status        = ST_ACK;
      end
      OP_START: begin
        active_nxt = 1'b0;
        if (no_more_r || !item.presence) begin
          last_disc_nxt = '0;
          no_more_nxt   = 1'b0;
          fam_disc_nxt  = '0;
          status        = ST_FAILED;
        end else begin
          active_nxt    = 1'b1;
          bit_pos_nxt   = FirstPosition;
          last_zero_nxt = '0;
          status        = ST_ACK;
        end
      end
      OP_BITS: begin
        if (active_r) begin
          if (item.id_bit && item.comp_bit) begin
            active_nxt    = 1'b0;
            last_disc_nxt = '0;
            no_more_nxt   = 1'b0;
            fam_disc_nxt  = '0;
            status        = ST_FAILED;
          end else begin
            last_zero_nxt = lz_new;
            if (item.id_bit == item.comp_bit && !dir && bit_pos_r < FamilyLimit) begin
              fam_disc_nxt = bit_pos_r[FamDiscW-1:0];
            end
            rom_nxt     = rom_upd;
            wvalid      = 1'b1;
            wbit        = dir;
            bit_pos_nxt = pos_inc;
            status      = ST_CONTINUE;
            if (pos_inc >= EndPosition) begin
              active_nxt    = 1'b0;
              last_disc_nxt = lz_new;
              if (lz_new == '0) begin
                no_more_nxt = 1'b1;
              end
              if (rom_upd[FamilyBits-1:0] == '0) begin
                last_disc_nxt = '0;
                no_more_nxt   = 1'b0;
                fam_disc_nxt  = '0;
                status        = ST_FAILED;
              end else begin
                count_nxt = count_r + 16'd1;
                status    = ST_FOUND;
              end
            end
          end
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r       <= '0;
      last_disc_r <= '0;
      fam_disc_r  <= '0;
      no_more_r   <= 1'b0;
      bit_pos_r   <= FirstPosition;
      last_zero_r <= '0;
      active_r    <= 1'b0;
      count_r     <= '0;
    end else if (step_en) begin
      rom_r       <= rom_nxt;
      last_disc_r <= last_disc_nxt;
      fam_disc_r  <= fam_disc_nxt;
      no_more_r   <= no_more_nxt;
      bit_pos_r   <= bit_pos_nxt;
      last_zero_r <= last_zero_nxt;
      active_r    <= active_nxt;
      count_r     <= count_nxt;
    end
  end

  assign res.status             = status;
  assign res.write_valid        = wvalid;
  assign res.write_bit          = wbit;
  assign res.rom_address        = rom_nxt;
  assign res.last_device        = no_more_nxt;
  assign res.family_discrepancy = fam_disc_nxt;
  assign res.device_count       = count_nxt;

  `OWS_ASSERT_NOW(a_pos_in_pass, active_r, (bit_pos_r >= FirstPosition) && (bit_pos_r < EndPosition), "bit position left the pass range")
  `OWS_ASSERT_NEXT(a_found_counts, step_en && status == ST_FOUND, count_r == $past(count_r) + 16'd1, "device count did not advance on a find")
  `OWS_ASSERT_NOW(a_fail_clears, step_en && status == ST_FAILED, !active_nxt && last_disc_nxt == '0, "failed request left a pass or discrepancy")

endmodule

/* design/onewire_rom_search.sv */
// Search-ROM decision engine for a 1-Wire bus master: one request per cycle while the
// output is not stalled, each answered by exactly one result. A request moves into an
// input register, is decided by the search state logic once the output side can advance,
// and lands in an output register, from which its result is presented; requests stream
// at one per cycle as long as results are taken or the output is empty.
// The output register frees the input side as long as the result is taken or the
// output is empty; a stalled output holds the input register and then the input.
// in_tuser carries the operation (clear, start pass, bit pair); out_tuser the status.
`include "onewire_rom_search_macros.svh"

module onewire_rom_search
  import ows_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] presence, [1] id_bit, [2] comp_bit, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [0] write_valid, [1] write_bit, [65:2] rom_address,
                                  // [66] last_device, [70:67] family_discrepancy,
                                  // [86:71] device_count, [87] zero
  output logic [2:0]  out_tuser   // [2:0] status
);

  logic    in_v_r;
  item_t   in_item_r;
  logic    out_v_r;
  result_t out_res_r;
  result_t res;
  logic    advance;
  logic    step_en;

  assign advance   = !out_v_r || out_tready;
  assign in_tready = !in_v_r || advance;
  assign step_en   = in_v_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.op       <= in_tuser;
      in_item_r.presence <= in_tdata[0];
      in_item_r.id_bit   <= in_tdata[1];
      in_item_r.comp_bit <= in_tdata[2];
    end
  end

  ows_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_en) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0, out_res_r.device_count, out_res_r.family_discrepancy,
                       out_res_r.last_device, out_res_r.rom_address,
                       out_res_r.write_bit, out_res_r.write_valid};

  `OWS_ASSERT_NOW(a_found_family, out_v_r && out_res_r.status == ST_FOUND, out_res_r.write_valid && out_res_r.rom_address[FamilyBits-1:0] != '0, "find reported with zero family code")
  `OWS_ASSERT_NOW(a_bit_needs_write, out_v_r && out_res_r.write_bit, out_res_r.write_valid, "direction bit set without a write")
  `OWS_ASSERT_NOW(a_no_write_on_ack, out_v_r && (out_res_r.status == ST_ACK || out_res_r.status == ST_IGNORED), !out_res_r.write_valid, "write flagged on a request that takes no bit")

endmodule
